// ===== rtl/sprite_frame_lookup_defines.svh =====
// Assertion macros for the sprite frame lookup block
`ifndef SPRITE_FRAME_LOOKUP_DEFINES_SVH
`define SPRITE_FRAME_LOOKUP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SFL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");
`define SFL_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("%m failed");
`else
`define SFL_ASSERT(label, clk, rst_n, prop)
`define SFL_ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// ===== rtl/sfl_pkg.sv =====
// ---------------------------------------------------------------------------
// sfl_pkg
// Types and constants of the sprite frame lookup block.
// ---------------------------------------------------------------------------
package sfl_pkg;
  localparam int MaxFrames  = 64;
  localparam int SheetBits  = 12;
  localparam int FracBits   = 16;
  localparam int LengthBits = 16;
  localparam int IdxW       = $clog2(MaxFrames);
  localparam int CntW       = IdxW + 1;
  localparam int TotW       = LengthBits + IdxW;
  localparam int NormW      = FracBits + 1;
  localparam int DimW       = SheetBits + 1;
  localparam int NumW       = DimW + FracBits;
  localparam int InW        = 2 + 2 * SheetBits + 2 * DimW + LengthBits + 32;
  localparam int InBytesW   = ((InW + 7) / 8) * 8;
  localparam int OutW       = 3 + IdxW + 4 * NormW + 1;
  localparam int OutBytesW  = ((OutW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_ZERO_LEN  = 3'd2,
    ST_NOT_SHEET = 3'd3,
    ST_FULL      = 3'd4,
    ST_BAD_OP    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_LOOP   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_NORM_INIT, S_NORM_DIV, S_NORM_NEXT, S_STORE,
    S_MOD, S_SEARCH, S_READ, S_READ_WAIT, S_OUT
  } state_e;
endpackage

// ===== rtl/sprite_frame_lookup.sv =====
// ---------------------------------------------------------------------------
// sprite_frame_lookup
// Frame table of a sprite-sheet animation: append, clear and time query.
// ---------------------------------------------------------------------------
// Clear, rejects, empty queries and bad operations go straight to the output;
// append runs four normalizations on one restoring divider, which the loop-mode
// floor modulo shares; query scans the stored frames, after a floor modulo in
// loop mode, and skips the scan and reads the last frame when once mode finished.
// One item at a time: s_axis_tready returns in the cycle after the output transfer.
// Reset empties the table and loads loop_mode 0 and sheet size 4096 x 4096.
module sprite_frame_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation, frame_x, frame_y, frame_w, frame_h, frame_length, query_time
  input  logic [sfl_pkg::InBytesW-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, frame_index, tex_u, tex_v, tex_w, tex_h, finished
  output logic [sfl_pkg::OutBytesW-1:0] m_axis_tdata
);
  import sfl_pkg::*;
  `include "sprite_frame_lookup_defines.svh"

  state_e state_q, state_d;
  logic loop_q;
  logic [DimW-1:0] sw_q, sh_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [TotW-1:0] tot_q, tot_d;

  logic [1:0] op_q;
  logic [SheetBits-1:0] x_q, y_q;
  logic [DimW-1:0] w_q, h_q;
  logic [LengthBits-1:0] len_q;
  logic signed [31:0] t_q;

  // shared restoring divider: rem/quot over up to 34 bits
  logic [33:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [5:0]  bit_q, bit_d;
  logic [1:0]  nsel_q, nsel_d;
  logic [NormW-1:0] nv_q [4];
  logic [NormW-1:0] nv_d [4];

  logic [IdxW-1:0] k_q, k_d, sel_q, sel_d;
  logic [TotW-1:0] tgt_q, tgt_d;
  logic fin_q, fin_d;
  status_e st_q, st_d;
  logic [OutW-1:0] res_q, res_d;
  logic vld_q, vld_d;

  logic [TotW-1:0] start_mem [MaxFrames];
  logic [4*NormW-1:0] rect_mem [MaxFrames];
  logic [TotW-1:0] start_rd_q;
  logic [4*NormW-1:0] rect_rd_q;
  logic [IdxW-1:0] rd_addr;
  logic wr_en;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE) && !vld_q;
  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {{(OutBytesW-OutW){1'b0}}, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q <= 1'b0;
      sw_q   <= DimW'(4096);
      sh_q   <= DimW'(4096);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOOP:   loop_q <= cfg_data_i[0];
        CFG_WIDTH:  sw_q   <= cfg_data_i;
        CFG_HEIGHT: sh_q   <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tdata[1:0];
      x_q   <= s_axis_tdata[2 +: SheetBits];
      y_q   <= s_axis_tdata[2+SheetBits +: SheetBits];
      w_q   <= s_axis_tdata[2+2*SheetBits +: DimW];
      h_q   <= s_axis_tdata[2+2*SheetBits+DimW +: DimW];
      len_q <= s_axis_tdata[2+2*SheetBits+2*DimW +: LengthBits];
      t_q   <= s_axis_tdata[2+2*SheetBits+2*DimW+LengthBits +: 32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[cnt_q[IdxW-1:0]] <= tot_q;
      rect_mem[cnt_q[IdxW-1:0]]  <= {nv_q[3], nv_q[2], nv_q[1], nv_q[0]};
    end
    start_rd_q <= start_mem[rd_addr];
    rect_rd_q  <= rect_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      tot_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tot_q   <= tot_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; bit_q <= bit_d;
    nsel_q <= nsel_d; k_q <= k_d; sel_q <= sel_d; tgt_q <= tgt_d;
    fin_q <= fin_d; st_q <= st_d; res_q <= res_d;
    for (int i = 0; i < 4; i++) nv_q[i] <= nv_d[i];
  end

  logic [DimW:0] xw_sum, yh_sum;
  logic [32:0] trial;
  logic [DimW-1:0] nsrc, ndiv;
  logic [32:0] tmag;
  logic [TotW-1:0] r_fix;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; tot_d = tot_q; vld_d = vld_q;
    num_d = num_q; rem_d = rem_q; den_d = den_q; bit_d = bit_q;
    nsel_d = nsel_q; k_d = k_q; sel_d = sel_q; tgt_d = tgt_q;
    fin_d = fin_q; st_d = st_q; res_d = res_q;
    for (int i = 0; i < 4; i++) nv_d[i] = nv_q[i];
    wr_en   = 1'b0;
    rd_addr = k_q;
    xw_sum  = {1'b0, x_q} + {1'b0, w_q};
    yh_sum  = {1'b0, y_q} + {1'b0, h_q};
    trial   = {rem_q[31:0], num_q[33]} - den_q;
    unique case (nsel_q)
      2'd0:    begin nsrc = {1'b0, x_q}; ndiv = sw_q; end
      2'd1:    begin nsrc = {1'b0, y_q}; ndiv = sh_q; end
      2'd2:    begin nsrc = w_q;         ndiv = sw_q; end
      default: begin nsrc = h_q;         ndiv = sh_q; end
    endcase
    tmag  = t_q[31] ? 33'(-$signed({t_q[31], t_q})) : {1'b0, t_q};
    r_fix = (t_q[31] && rem_q != '0) ? TotW'(den_q - rem_q) : TotW'(rem_q);
    if (vld_q && m_axis_tready) vld_d = 1'b0;

    unique case (state_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = S_DECODE;
      S_DECODE: begin
        st_d = ST_OK; fin_d = 1'b0; sel_d = '0; k_d = '0; res_d = '0;
        state_d = S_OUT;
        unique case (op_e'(op_q))
          OP_CLEAR: begin cnt_d = '0; tot_d = '0; end
          OP_APPEND: begin
            if (cnt_q >= CntW'(MaxFrames)) st_d = ST_FULL;
            else if (len_q == '0) st_d = ST_ZERO_LEN;
            else if (w_q == '0 || h_q == '0 || sw_q == '0 || sh_q == '0 ||
                     xw_sum > {1'b0, sw_q} || yh_sum > {1'b0, sh_q})
              st_d = ST_NOT_SHEET;
            else begin nsel_d = 2'd0; state_d = S_NORM_INIT; end
          end
          OP_QUERY: begin
            if (cnt_q == '0 || tot_q == '0) st_d = ST_EMPTY;
            else if (loop_q) begin
              num_d = {1'b0, tmag}; rem_d = '0; den_d = 33'(tot_q);
              bit_d = 6'd34; state_d = S_MOD;
            end else if (!t_q[31] && 33'(t_q) >= 33'(tot_q)) begin
              fin_d = 1'b1; k_d = IdxW'(cnt_q - 1'b1); state_d = S_READ;
            end else begin
              tgt_d = t_q[31] ? '0 : TotW'(t_q); bit_d = '0; state_d = S_SEARCH;
            end
          end
          default: st_d = ST_BAD_OP;
        endcase
      end
      S_NORM_INIT: begin
        num_d = 34'({nsrc, {FracBits{1'b0}}} + (ndiv >> 1)) << (34 - NumW);
        rem_d = '0; den_d = 33'(ndiv); bit_d = 6'(NumW);
        state_d = S_NORM_DIV;
      end
      S_NORM_DIV, S_MOD: begin
        if (!trial[32]) rem_d = trial; else rem_d = {rem_q[31:0], num_q[33]};
        num_d = {num_q[32:0], !trial[32]};
        bit_d = bit_q - 1'b1;
        if (bit_q == 6'd1) begin
          if (state_q == S_MOD) state_d = S_SEARCH;
          else state_d = S_NORM_NEXT;
        end
      end
      S_NORM_NEXT: begin
        nv_d[nsel_q] = num_q[NormW-1:0];
        nsel_d = nsel_q + 1'b1;
        state_d = (nsel_q == 2'd3) ? S_STORE : S_NORM_INIT;
      end
      S_STORE: begin
        wr_en = 1'b1; sel_d = cnt_q[IdxW-1:0];
        cnt_d = cnt_q + 1'b1; tot_d = tot_q + TotW'(len_q);
        res_d = {1'b0, nv_q[3], nv_q[2], nv_q[1], nv_q[0], cnt_q[IdxW-1:0], ST_OK};
        state_d = S_OUT;
      end
      S_SEARCH: begin
        if (loop_q && k_q == '0 && bit_q == '0) begin
          tgt_d = r_fix; bit_d = 6'd63; rd_addr = '0;
        end else begin
          // scan: compare previous read against the target, one entry a cycle
          if (bit_q != 6'd63) bit_d = 6'd63;
          else begin
            if (start_rd_q <= tgt_q) sel_d = k_q;
            if (CntW'(k_q) + 1'b1 >= cnt_q) begin k_d = sel_d; state_d = S_READ; end
            else k_d = k_q + 1'b1;
            rd_addr = k_d;
          end
        end
      end
      S_READ: state_d = S_READ_WAIT;
      S_READ_WAIT: begin
        res_d = {fin_q, rect_rd_q, k_q, ST_OK};
        st_d = ST_OK;
        vld_d = 1'b1; state_d = S_IDLE;
      end
      S_OUT: begin
        if (st_q != ST_OK) res_d = {{(OutW-3){1'b0}}, st_q};
        vld_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  `SFL_ASSERT(a_no_accept_busy, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |-> !vld_q)
  `SFL_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(MaxFrames))
  `SFL_ASSERT_NEVER(a_write_full, clk_i, rst_ni, wr_en && cnt_q >= CntW'(MaxFrames))
endmodule
